### src/b32ps_pkg.sv
// Shared constants and character-class functions for the base32 hash and path scanner.
// No dependencies; imported by the top level.
package b32ps_pkg;

   localparam int PREFIX_LEN = 11;
   localparam int PREFIX_W   = 4;
   localparam int NAME_MAX   = 211;
   localparam int NAME_SAT   = 255;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;

   // Bytes of the store prefix, slash-led and slash-terminated.
   function automatic logic [7:0] prefix_byte(input logic [PREFIX_W-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         4'd0:    b = 8'h2F;
         4'd1:    b = 8'h6E;
         4'd2:    b = 8'h69;
         4'd3:    b = 8'h78;
         4'd4:    b = 8'h2F;
         4'd5:    b = 8'h73;
         4'd6:    b = 8'h74;
         4'd7:    b = 8'h6F;
         4'd8:    b = 8'h72;
         4'd9:    b = 8'h65;
         4'd10:   b = 8'h2F;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Digits and lowercase letters without e, o, t and u.
   function automatic logic is_alphabet(input logic [7:0] c);
      logic digit;
      logic lower;
      digit = (c >= 8'h30) && (c <= 8'h39);
      lower = (c >= 8'h61) && (c <= 8'h7A) &&
              (c != 8'h65) && (c != 8'h6F) && (c != 8'h75) && (c != 8'h74);
      return digit || lower;
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      logic alnum;
      alnum = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
              ((c >= 8'h41) && (c <= 8'h5A));
      return alnum || (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2E) ||
             (c == 8'h5F) || (c == 8'h3F) || (c == 8'h3D);
   endfunction

endpackage

### src/base32_hash_and_path_scanner.sv
// Top level of the base32 hash and path scanner: state registers, per-byte logic, result register.
// Depends on b32ps_pkg for the prefix table and character classes.

// Scans one byte per cycle. Every request is taken in the cycle it is offered as long as the
// result register is empty or being drained, so the sustained rate is one byte per clock; the
// per-byte work is a handful of compares and counter updates between the scan state registers
// and the result register, and a result appears in the cycle after the byte that causes it. A
// result carries a hash hit (tuser[0]) with the offset of the byte that closes a run of
// HASH_CHARS alphabet bytes, a completed store path (tuser[1]) with its start offset and total
// length, or both. Bytes that cause neither produce no result. All scan state, including the
// byte offset, returns to its reset value after a request with tlast set.
module base32_hash_and_path_scanner
   import b32ps_pkg::*;
#(
   parameter int HASH_CHARS  = 32,
   parameter int OFFSET_BITS = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [47:0] hash_end_offset, [95:48] path_start_offset,
                                     // [103:96] path_length
   output logic [1:0]   rsp_tuser    // [0] hash_found, [1] path_found
);

   localparam int RUN_W = $clog2(HASH_CHARS + 1);
   localparam logic [RUN_W-1:0]       RUN_FULL    = RUN_W'(HASH_CHARS);
   localparam logic [7:0]             HASH_LEN8   = 8'(HASH_CHARS);
   localparam logic [7:0]             NAME_MIN8   = 8'(HASH_CHARS + 2);
   localparam logic [7:0]             NAME_MAX8   = 8'(NAME_MAX);
   localparam logic [7:0]             NAME_SAT8   = 8'(NAME_SAT);
   localparam logic [7:0]             PREFIX_LEN8 = 8'(PREFIX_LEN);
   localparam logic [PREFIX_W-1:0]    PREFIX_END  = PREFIX_W'(PREFIX_LEN);
   localparam logic [OFFSET_BITS-1:0] START_BACK  = OFFSET_BITS'(PREFIX_LEN - 1);

   logic [OFFSET_BITS-1:0] position_ff, position_in;
   logic [RUN_W-1:0]       run_ff, run_in;
   logic [PREFIX_W-1:0]    matched_ff, matched_in;
   logic                   in_path_ff, in_path_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [7:0]             name_len_ff, name_len_in;
   logic                   hash_ok_ff, hash_ok_in;
   logic                   dash_ff, dash_in;

   logic                   valid_ff;
   logic                   hash_found_ff, path_found_ff;
   logic [47:0]            hash_off_ff, path_off_ff;
   logic [7:0]             path_len_ff;

   logic                   accept;
   logic [7:0]             c;
   logic                   alpha, name_ch;
   logic                   hash_hit, path_hit;
   logic [OFFSET_BITS-1:0] hit_start;
   logic [7:0]             hit_len;
   logic [PREFIX_W-1:0]    match_idx, match_cnt;
   logic                   match_done;
   logic [63:0]            pos_wide, start_wide;

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign alpha      = is_alphabet(c);
   assign name_ch    = is_name_char(c);

   // Prefix matcher: fall back to one on a slash, else to zero.
   always_comb begin
      match_idx = (matched_ff < PREFIX_END) ? matched_ff : '0;
      if (c == prefix_byte(match_idx)) begin
         match_cnt = match_idx + PREFIX_W'(1);
      end else if (c == CHAR_SLASH) begin
         match_cnt = PREFIX_W'(1);
      end else begin
         match_cnt = '0;
      end
      match_done = (match_cnt == PREFIX_END);
   end

   always_comb begin
      run_in      = run_ff;
      matched_in  = matched_ff;
      in_path_in  = in_path_ff;
      start_in    = start_ff;
      name_len_in = name_len_ff;
      hash_ok_in  = hash_ok_ff;
      dash_in     = dash_ff;
      path_hit    = 1'b0;
      hit_start   = '0;
      hit_len     = '0;

      if (alpha) begin
         if (run_ff < RUN_FULL) begin
            run_in = run_ff + RUN_W'(1);
         end
      end else begin
         run_in = '0;
      end
      hash_hit = alpha && (run_in >= RUN_FULL);

      if (in_path_ff && name_ch) begin
         if ((name_len_ff < HASH_LEN8) && !alpha) begin
            hash_ok_in = 1'b0;
         end
         if ((name_len_ff == HASH_LEN8) && (c == CHAR_DASH)) begin
            dash_in = 1'b1;
         end
         if (name_len_ff < NAME_SAT8) begin
            name_len_in = name_len_ff + 8'd1;
         end
      end else begin
         if (in_path_ff) begin
            // Judge the path closed by this byte, then try the byte as a new prefix.
            hit_start   = start_ff;
            hit_len     = name_len_ff + PREFIX_LEN8;
            path_hit    = (name_len_ff >= NAME_MIN8) && (name_len_ff <= NAME_MAX8) &&
                          hash_ok_ff && dash_ff;
            in_path_in  = 1'b0;
            name_len_in = '0;
            hash_ok_in  = 1'b1;
            dash_in     = 1'b0;
         end
         matched_in = match_cnt;
         if (match_done) begin
            in_path_in  = 1'b1;
            start_in    = position_ff - START_BACK;
            name_len_in = '0;
            hash_ok_in  = 1'b1;
            dash_in     = 1'b0;
            matched_in  = '0;
         end
      end

      position_in = position_ff + OFFSET_BITS'(1);
      if (req_tlast) begin
         if (in_path_in) begin
            hit_start = start_in;
            hit_len   = name_len_in + PREFIX_LEN8;
            path_hit  = (name_len_in >= NAME_MIN8) && (name_len_in <= NAME_MAX8) &&
                        hash_ok_in && dash_in;
         end
         position_in = '0;
         run_in      = '0;
         matched_in  = '0;
         in_path_in  = 1'b0;
         start_in    = '0;
         name_len_in = '0;
         hash_ok_in  = 1'b1;
         dash_in     = 1'b0;
      end
   end

   assign pos_wide   = 64'(position_ff);
   assign start_wide = 64'(hit_start);

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         run_ff      <= '0;
         matched_ff  <= '0;
         in_path_ff  <= 1'b0;
         start_ff    <= '0;
         name_len_ff <= '0;
         hash_ok_ff  <= 1'b1;
         dash_ff     <= 1'b0;
      end else if (accept) begin
         position_ff <= position_in;
         run_ff      <= run_in;
         matched_ff  <= matched_in;
         in_path_ff  <= in_path_in;
         start_ff    <= start_in;
         name_len_ff <= name_len_in;
         hash_ok_ff  <= hash_ok_in;
         dash_ff     <= dash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= hash_hit || path_hit;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // Load the result register whenever a request is taken; zero the fields of an absent finding.
   always_ff @(posedge clock) begin
      if (accept) begin
         hash_found_ff <= hash_hit;
         path_found_ff <= path_hit;
         hash_off_ff   <= hash_hit ? pos_wide[47:0] : 48'd0;
         path_off_ff   <= path_hit ? start_wide[47:0] : 48'd0;
         path_len_ff   <= path_hit ? hit_len : 8'd0;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {path_len_ff, path_off_ff, hash_off_ff};
   assign rsp_tuser  = {path_found_ff, hash_found_ff};

endmodule

### verif/base32_hash_and_path_scanner_tb.sv
// Self-checking testbench for base32_hash_and_path_scanner: directed and random byte streams,
// a byte-level predictor of hash runs and store paths, and a result checker.
// Depends on b32ps_pkg and the scanner RTL.
module base32_hash_and_path_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b32ps_pkg::*;

   localparam int HASH_LEN       = 32;
   localparam int NAME_MIN       = HASH_LEN + 2;
   localparam int WATCHDOG_LIMIT = 4000;

   // store prefix, first byte in the top bits
   localparam logic [8*PREFIX_LEN-1:0] STORE_PFX = {
      8'h2F, 8'h6E, 8'h69, 8'h78, 8'h2F, 8'h73, 8'h74, 8'h6F, 8'h72, 8'h65, 8'h2F
   };

   typedef struct packed {
      logic        hash_hit;
      logic [47:0] hash_pos;
      logic        path_hit;
      logic [47:0] path_pos;
      logic [7:0]  path_len;
   } scan_hit_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;   // [7:0] data_byte
   logic         req_tlast  = 1'b0; // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;         // [47:0] hash_end_offset, [95:48] path_start_offset,
                                    // [103:96] path_length
   logic [1:0]   rsp_tuser;         // [0] hash_found, [1] path_found

   // predictor state
   logic [47:0] scan_pos;
   int          run_len;
   int          pfx_cnt;
   bit          path_open;
   logic [47:0] path_base;
   int          name_len;
   bit          name_b32_ok;
   bit          dash_ok;

   scan_hit_type expected_hits[$];
   scan_hit_type got_hit;
   int          fail_count     = 0;
   int          quiet_cycles   = 0;
   int          items_sent     = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   base32_hash_and_path_scanner #(
      .HASH_CHARS (HASH_LEN),
      .OFFSET_BITS(48)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit is_b32(logic [7:0] c);
      bit digit;
      bit lower;
      digit = (c >= 8'h30) && (c <= 8'h39);
      lower = (c >= 8'h61) && (c <= 8'h7A) &&
              !(c == 8'h65 || c == 8'h6F || c == 8'h74 || c == 8'h75);
      return digit || lower;
   endfunction

   function automatic bit is_name_char(logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             ((c >= 8'h41) && (c <= 8'h5A)) || c == 8'h2B || c == CHAR_DASH ||
             c == 8'h2E || c == 8'h5F || c == 8'h3F || c == 8'h3D;
   endfunction

   function automatic void clear_scan();
      scan_pos    = '0;
      run_len     = 0;
      pfx_cnt     = 0;
      path_open   = 1'b0;
      path_base   = '0;
      name_len    = 0;
      name_b32_ok = 1'b1;
      dash_ok     = 1'b0;
   endfunction

   function automatic void track_prefix(logic [7:0] c);
      int idx;
      idx = (pfx_cnt < PREFIX_LEN) ? pfx_cnt : 0;
      if (c == STORE_PFX[8*(PREFIX_LEN-1-idx) +: 8]) pfx_cnt = idx + 1;
      else pfx_cnt = (c == CHAR_SLASH) ? 1 : 0;
      if (pfx_cnt == PREFIX_LEN) begin
         path_open   = 1'b1;
         path_base   = scan_pos - 48'(PREFIX_LEN - 1);
         name_len    = 0;
         name_b32_ok = 1'b1;
         dash_ok     = 1'b0;
         pfx_cnt     = 0;
      end
   endfunction

   // Judge the open path into the hit record, then close it.
   function automatic void close_path(inout scan_hit_type hit);
      hit.path_pos = path_base;
      hit.path_len = 8'(name_len + PREFIX_LEN);
      hit.path_hit = name_len >= NAME_MIN && name_len <= NAME_MAX && name_b32_ok && dash_ok;
      path_open    = 1'b0;
      name_len     = 0;
      name_b32_ok  = 1'b1;
      dash_ok      = 1'b0;
   endfunction

   function automatic void scan_byte(logic [7:0] c, logic is_last);
      scan_hit_type hit;
      hit = '0;
      if (is_b32(c)) begin
         if (run_len < HASH_LEN) run_len++;
         if (run_len >= HASH_LEN) begin
            hit.hash_hit = 1'b1;
            hit.hash_pos = scan_pos;
         end
      end else begin
         run_len = 0;
      end
      if (!path_open) begin
         track_prefix(c);
      end else if (is_name_char(c)) begin
         if (name_len < HASH_LEN && !is_b32(c)) name_b32_ok = 1'b0;
         if (name_len == HASH_LEN && c == CHAR_DASH) dash_ok = 1'b1;
         if (name_len < NAME_SAT) name_len++;
      end else begin
         // the terminating byte may open the next prefix
         close_path(hit);
         track_prefix(c);
      end
      if (is_last) begin
         if (path_open) close_path(hit);
         clear_scan();
      end else begin
         scan_pos++;
      end
      if (!hit.path_hit) begin
         hit.path_pos = '0;
         hit.path_len = '0;
      end
      if (hit.hash_hit || hit.path_hit) expected_hits = {expected_hits, hit};
   endfunction

   // ---------------------------------------------------------------- receive side

   always @(negedge clock) begin
      rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
      if (exp !== act) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               $error("unexpected result: tuser %0h, tdata %0h", rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               got_hit = expected_hits.pop_front();
               check_field("hash_found", got_hit.hash_hit, rsp_tuser[0]);
               check_field("hash_end_offset", got_hit.hash_pos, rsp_tdata[47:0]);
               check_field("path_found", got_hit.path_hit, rsp_tuser[1]);
               check_field("path_start_offset", got_hit.path_pos, rsp_tdata[95:48]);
               check_field("path_length", got_hit.path_len, rsp_tdata[103:96]);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- send side

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      @(negedge clock);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scan_byte(b, is_last);
      items_sent++;
   endtask

   // Drop valid and hold until every expected result has been taken.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_b32();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (!is_b32(c));
      return c;
   endfunction

   function automatic logic [7:0] rand_name_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (!is_name_char(c));
      return c;
   endfunction

   function automatic logic [7:0] rand_stop_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (is_name_char(c));
      return c;
   endfunction

   task automatic send_prefix(input int from, input int upto, input bit last_on_end);
      for (int i = from; i <= upto; i++)
         send_byte(STORE_PFX[8*(PREFIX_LEN-1-i) +: 8], last_on_end && i == upto);
   endtask

   task automatic send_alpha_run(input int n, input bit last_on_end);
      for (int i = 0; i < n; i++) send_byte(rand_b32(), last_on_end && i == n - 1);
   endtask

   // Prefix (from the given byte on), then a name: hash part, optional dash, free tail.
   task automatic send_path(input int len, input int bad_pos, input bit with_dash,
                            input bit last_on_end, input int pfx_from);
      logic [7:0] c;
      send_prefix(pfx_from, PREFIX_LEN - 1, 1'b0);
      for (int i = 0; i < len; i++) begin
         if (i < HASH_LEN) begin
            if (i == bad_pos) begin
               do c = rand_name_char(); while (is_b32(c));
            end else begin
               c = rand_b32();
            end
         end else if (i == HASH_LEN) begin
            c = with_dash ? CHAR_DASH : rand_b32();
         end else begin
            c = rand_name_char();
         end
         send_byte(c, last_on_end && i == len - 1);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_field_extremes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
   endtask

   task automatic test_hash_runs();
      // run past saturation, break it, then close a fresh run on the last byte
      send_alpha_run(HASH_LEN + 2, 1'b0);
      send_byte(8'h65, 1'b0);
      send_alpha_run(HASH_LEN, 1'b1);
   endtask

   task automatic test_path_bounds();
      send_path(NAME_MIN, -1, 1'b1, 1'b0, 0);
      send_byte(rand_stop_byte(), 1'b0);
      send_path(NAME_MIN - 1, -1, 1'b1, 1'b0, 0);
      send_byte(rand_stop_byte(), 1'b0);
      send_path(NAME_MAX, -1, 1'b1, 1'b0, 0);
      send_byte(rand_stop_byte(), 1'b0);
      send_path(NAME_MAX + 1, -1, 1'b1, 1'b0, 0);
      send_byte(rand_stop_byte(), 1'b0);
      // name length saturates
      send_path(NAME_SAT + 1, -1, 1'b1, 1'b0, 0);
      send_byte(rand_stop_byte(), 1'b0);
      send_path(40, 5, 1'b1, 1'b0, 0);
      send_byte(rand_stop_byte(), 1'b0);
      send_path(40, -1, 1'b0, 1'b0, 0);
      send_byte(rand_stop_byte(), 1'b1);
   endtask

   task automatic test_prefix_handoff();
      // partial prefix, slash falls back to a one-byte match
      send_byte(CHAR_SLASH, 1'b0);
      send_byte(8'h6E, 1'b0);
      send_byte(8'h69, 1'b0);
      send_path(40, -1, 1'b1, 1'b0, 0);
      // the ending slash starts the next prefix
      send_byte(CHAR_SLASH, 1'b0);
      send_path(HASH_LEN + 1, -1, 1'b1, 1'b0, 1);
      // hash hit and path hit on the same last byte
      send_alpha_run(HASH_LEN, 1'b1);
      send_prefix(0, 6, 1'b1);
      // empty name
      send_prefix(0, PREFIX_LEN - 1, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h0A, 1'b1);
   endtask

   task automatic test_random_streams(input int idle_pct, input int stall_pct, input int n);
      int stop_at;
      int len;
      bit end_last;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at        = items_sent + n;
      while (items_sent < stop_at) begin
         case ($urandom_range(99)) inside
            [0:54]: begin
               len      = ($urandom_range(9) == 0) ? $urandom_range(1, 240)
                                                   : $urandom_range(30, 70);
               end_last = ($urandom_range(11) == 0);
               send_path(len, ($urandom_range(7) == 0) ? int'($urandom_range(31)) : -1,
                         $urandom_range(9) != 0, end_last, 0);
               if (!end_last) send_byte(rand_stop_byte(), $urandom_range(19) == 0);
            end
            [55:69]: begin
               send_prefix(0, $urandom_range(9), 1'b0);
               send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
            end
            [70:84]: begin
               send_alpha_run($urandom_range(1, 50), 1'b0);
               send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
            end
            default: begin
               repeat ($urandom_range(1, 20))
                  send_byte(8'($urandom_range(255)), $urandom_range(31) == 0);
            end
         endcase
      end
      wait_for_results();
   endtask

   initial begin
      clear_scan();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_hash_runs();
      test_path_bounds();
      test_prefix_handoff();
      test_random_streams(0, 0, 25);
      test_random_streams(63, 0, 25);
      test_random_streams(0, 63, 25);
      test_random_streams(11, 11, 25);

      wait_for_results();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && expected_hits.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
src/b32ps_pkg.sv
src/base32_hash_and_path_scanner.sv
verif/base32_hash_and_path_scanner_tb.sv
